FILE: src/lspf_pkg.sv
// Package of the line segment proximity filter: widths, register indexes
// and the structs passed between the modules.
// No dependencies.
`default_nettype none

package lspf_pkg;

	localparam int COORD_WIDTH     = 20;
	localparam int INDEX_WIDTH     = 16;
	localparam int MARGIN_WIDTH    = COORD_WIDTH - 1;
	localparam int LEVEL_REG_WIDTH = 6;
	localparam int LEVEL_WIDTH     = 5;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = COORD_WIDTH;

	// Line coefficients a = y1-y2, b = x2-x1 and c = x1*y2 - y1*x2.
	// The most negative coordinate squared needs the full product width.
	localparam int LINE_WIDTH  = COORD_WIDTH + 1;
	localparam int CROSS_WIDTH = 2 * COORD_WIDTH;
	localparam int C_WIDTH     = 2 * COORD_WIDTH;

	// Point side: a*x, a*x+b*y+c, its magnitude and its square.
	localparam int TERM_WIDTH   = LINE_WIDTH + COORD_WIDTH;
	localparam int SUM_WIDTH    = 2 * COORD_WIDTH + 3;
	localparam int MAG_WIDTH    = SUM_WIDTH - 1;
	localparam int MAG_LO_WIDTH = MAG_WIDTH / 2;
	localparam int MAG_HI_WIDTH = MAG_WIDTH - MAG_LO_WIDTH;
	localparam int PART_WIDTH   = MAG_HI_WIDTH + 2 * MAG_LO_WIDTH + 2;
	localparam int SQ_WIDTH     = 2 * MAG_WIDTH;

	// Line side: a^2+b^2, margin*(a^2+b^2) and margin^2*(a^2+b^2).
	localparam int NORM_WIDTH    = 2 * LINE_WIDTH;
	localparam int NORM_LO_WIDTH = NORM_WIDTH / 2;
	localparam int NORM_HI_WIDTH = NORM_WIDTH - NORM_LO_WIDTH;
	localparam int MN_WIDTH      = MARGIN_WIDTH + NORM_WIDTH;
	localparam int MN_LO_WIDTH   = (MN_WIDTH + 1) / 2;
	localparam int MN_HI_WIDTH   = MN_WIDTH - MN_LO_WIDTH;
	localparam int BOUND_WIDTH   = MARGIN_WIDTH + MN_WIDTH;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_START_X = 3'd0,
		REG_START_Y = 3'd1,
		REG_END_X   = 3'd2,
		REG_END_Y   = 3'd3,
		REG_MARGIN  = 3'd4,
		REG_LOW_LVL = 3'd5,
		REG_HIGH_LVL = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
		logic [MARGIN_WIDTH-1:0]       margin;
	} ref_cfg_t;

	typedef struct packed {
		logic signed [LINE_WIDTH-1:0] a;
		logic signed [LINE_WIDTH-1:0] b;
		logic signed [C_WIDTH-1:0]    c;
		logic [BOUND_WIDTH-1:0]       bound;
	} line_coef_t;

endpackage

`default_nettype wire

FILE: src/lspf_seg_if.sv
// Input channel of the proximity filter: one candidate segment per word.
// Depends on lspf_pkg.
`default_nettype none

interface lspf_seg_if import lspf_pkg::*; ();

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] seg_start_x;
	logic signed [COORD_WIDTH-1:0] seg_start_y;
	logic signed [COORD_WIDTH-1:0] seg_end_x;
	logic signed [COORD_WIDTH-1:0] seg_end_y;
	logic [LEVEL_WIDTH-1:0]        seg_level;
	logic [INDEX_WIDTH-1:0]        seg_index;
	logic                          seg_last;

	modport source (
		output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		output seg_level, seg_index, seg_last,
		input  ready
	);

	modport sink (
		input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		input  seg_level, seg_index, seg_last,
		output ready
	);

endinterface

`default_nettype wire

FILE: src/lspf_res_if.sv
// Result channel of the proximity filter: one verdict word per segment.
// Depends on lspf_pkg.
`default_nettype none

interface lspf_res_if import lspf_pkg::*; ();

	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic [INDEX_WIDTH-1:0] out_index;
	logic                   out_last;

	modport source (
		output valid, accepted, out_index, out_last,
		input  ready
	);

	modport sink (
		input  valid, accepted, out_index, out_last,
		output ready
	);

endinterface

`default_nettype wire

FILE: src/line_segment_proximity_filter.sv
// Line segment proximity filter. Each input word is one candidate segment; one
// verdict word comes out per segment, in order. A new segment is accepted in
// every cycle in which the pipeline does not hold: the datapath is an
// eight-stage pipeline (input register, a*x and b*y products,
// line sum, magnitude, split square, two adder stages and the output register)
// that holds as a whole only while a finished verdict is not taken. A segment
// is rejected when an endpoint gives (a*x+b*y+c)^2 > margin^2*(a^2+b^2), or by
// the pyramid level range. The line coefficients and the bound are derived
// from the configuration registers in a separate seven-stage pipeline.
`default_nettype none

module line_segment_proximity_filter import lspf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	lspf_seg_if.sink                   seg,
	lspf_res_if.source                 res
);

	typedef struct packed {
		logic                   ok;
		logic [INDEX_WIDTH-1:0] index;
		logic                   last;
	} seg_tag_t;

	ref_cfg_t                          cfg_q;
	logic signed [LEVEL_REG_WIDTH-1:0] low_lvl_q, high_lvl_q;
	line_coef_t                        coef;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic res_v_q;

	logic signed [COORD_WIDTH-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic [LEVEL_WIDTH-1:0]        level_s1;
	logic [INDEX_WIDTH-1:0]        index_s1;
	logic                          last_s1;
	seg_tag_t tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;

	logic                        accepted_q;
	logic [INDEX_WIDTH-1:0]      index_q;
	logic                        last_q;

	logic signed [LEVEL_REG_WIDTH:0] level_ext, low_ext, high_ext;
	logic                            lvl_check, lvl_ok;
	logic [SQ_WIDTH-1:0]             sq_start, sq_end;
	logic [SQ_WIDTH-1:0]             bound_ext;
	logic                            far;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= '0;
			low_lvl_q  <= '1;
			high_lvl_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X:  cfg_q.start_x <= cfg_data[COORD_WIDTH-1:0];
				REG_START_Y:  cfg_q.start_y <= cfg_data[COORD_WIDTH-1:0];
				REG_END_X:    cfg_q.end_x   <= cfg_data[COORD_WIDTH-1:0];
				REG_END_Y:    cfg_q.end_y   <= cfg_data[COORD_WIDTH-1:0];
				REG_MARGIN:   cfg_q.margin  <= cfg_data[MARGIN_WIDTH-1:0];
				REG_LOW_LVL:  low_lvl_q     <= cfg_data[LEVEL_REG_WIDTH-1:0];
				REG_HIGH_LVL: high_lvl_q    <= cfg_data[LEVEL_REG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	lspf_ref_line u_ref_line (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.coef   (coef)
	);

	// The whole pipeline moves unless a verdict waits at the output.
	assign en        = !res_v_q || res.ready;
	assign seg.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			res_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= seg.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6    <= v_s5;
			v_s7    <= v_s6;
			res_v_q <= v_s7;
		end
	end

	// Level range check. A low limit of zero or less never rejects, and a
	// high limit of zero never rejects either.
	assign level_ext = $signed({2'b00, level_s1});
	assign low_ext   = (LEVEL_REG_WIDTH + 1)'(low_lvl_q);
	assign high_ext  = (LEVEL_REG_WIDTH + 1)'(high_lvl_q);
	assign lvl_check = (low_lvl_q > 0) || (high_lvl_q >= 0);
	assign lvl_ok    = !(lvl_check && ((level_ext < low_ext)
		|| ((high_lvl_q > 0) && (level_ext > high_ext))));

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1    <= seg.seg_start_x;
			sy_s1    <= seg.seg_start_y;
			ex_s1    <= seg.seg_end_x;
			ey_s1    <= seg.seg_end_y;
			level_s1 <= seg.seg_level;
			index_s1 <= seg.seg_index;
			last_s1  <= seg.seg_last;

			tag_s2 <= '{ok: lvl_ok, index: index_s1, last: last_s1};
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;

			accepted_q <= tag_s7.ok && !far;
			index_q    <= tag_s7.index;
			last_q     <= tag_s7.last;
		end
	end

	lspf_point_dist u_dist_start (
		.clk  (clk),
		.en   (en),
		.x    (sx_s1),
		.y    (sy_s1),
		.coef (coef),
		.sq   (sq_start)
	);

	lspf_point_dist u_dist_end (
		.clk  (clk),
		.en   (en),
		.x    (ex_s1),
		.y    (ey_s1),
		.coef (coef),
		.sq   (sq_end)
	);

	// A distance exactly on the margin still passes.
	assign bound_ext = SQ_WIDTH'(coef.bound);
	assign far       = (sq_start > bound_ext) || (sq_end > bound_ext);

	assign res.valid     = res_v_q;
	assign res.accepted  = accepted_q;
	assign res.out_index = index_q;
	assign res.out_last  = last_q;

endmodule

`default_nettype wire

FILE: src/lspf_ref_line.sv
// Reference line coefficients and the squared-margin bound, computed from the
// configuration registers in a free-running seven-stage pipeline.
// Depends on lspf_pkg.
`default_nettype none

module lspf_ref_line import lspf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ref_cfg_t   cfg,
	output line_coef_t coef
);

	logic signed [LINE_WIDTH-1:0]  a_s1, b_s1;
	logic signed [CROSS_WIDTH-1:0] xy_s1, yx_s1;
	logic [MARGIN_WIDTH-1:0]       m_s1, m_s2, m_s3, m_s4, m_s5;
	logic signed [C_WIDTH-1:0]     c_s2;
	logic [NORM_WIDTH-1:0]         aa_s2, bb_s2;
	logic [NORM_WIDTH-1:0]         norm_s3;
	logic [MARGIN_WIDTH+NORM_LO_WIDTH-1:0] mn_lo_s4;
	logic [MARGIN_WIDTH+NORM_HI_WIDTH-1:0] mn_hi_s4;
	logic [MN_WIDTH-1:0]           mn_s5;
	logic [MARGIN_WIDTH+MN_LO_WIDTH-1:0] bnd_lo_s6;
	logic [MARGIN_WIDTH+MN_HI_WIDTH-1:0] bnd_hi_s6;
	logic [BOUND_WIDTH-1:0]        bound_s7;

	logic signed [COORD_WIDTH-1:0] x1, y1, x2, y2;
	logic signed [CROSS_WIDTH-1:0] xy_c, yx_c;
	logic signed [NORM_WIDTH-1:0]  aa_c, bb_c;
	logic [MARGIN_WIDTH+NORM_LO_WIDTH-1:0] mn_lo_c;
	logic [MARGIN_WIDTH+NORM_HI_WIDTH-1:0] mn_hi_c;
	logic [MARGIN_WIDTH+MN_LO_WIDTH-1:0]   bnd_lo_c;
	logic [MARGIN_WIDTH+MN_HI_WIDTH-1:0]   bnd_hi_c;

	assign x1 = cfg.start_x;
	assign y1 = cfg.start_y;
	assign x2 = cfg.end_x;
	assign y2 = cfg.end_y;

	assign xy_c = x1 * y2;
	assign yx_c = y1 * x2;
	assign aa_c = a_s1 * a_s1;
	assign bb_c = b_s1 * b_s1;

	// The norm is split in halves so that each product stays narrow.
	assign mn_lo_c = m_s3 * norm_s3[NORM_LO_WIDTH-1:0];
	assign mn_hi_c = m_s3 * norm_s3[NORM_WIDTH-1:NORM_LO_WIDTH];
	assign bnd_lo_c = m_s5 * mn_s5[MN_LO_WIDTH-1:0];
	assign bnd_hi_c = m_s5 * mn_s5[MN_WIDTH-1:MN_LO_WIDTH];

	// The reset values match the all-zero reference line, so the outputs are
	// valid straight out of reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s1      <= '0;
			b_s1      <= '0;
			xy_s1     <= '0;
			yx_s1     <= '0;
			m_s1      <= '0;
			c_s2      <= '0;
			aa_s2     <= '0;
			bb_s2     <= '0;
			m_s2      <= '0;
			norm_s3   <= '0;
			m_s3      <= '0;
			mn_lo_s4  <= '0;
			mn_hi_s4  <= '0;
			m_s4      <= '0;
			mn_s5     <= '0;
			m_s5      <= '0;
			bnd_lo_s6 <= '0;
			bnd_hi_s6 <= '0;
			bound_s7  <= '0;
		end else begin
			a_s1  <= LINE_WIDTH'(y1) - LINE_WIDTH'(y2);
			b_s1  <= LINE_WIDTH'(x2) - LINE_WIDTH'(x1);
			xy_s1 <= xy_c;
			yx_s1 <= yx_c;
			m_s1  <= cfg.margin;

			c_s2  <= C_WIDTH'(xy_s1) - C_WIDTH'(yx_s1);
			aa_s2 <= aa_c;
			bb_s2 <= bb_c;
			m_s2  <= m_s1;

			norm_s3 <= aa_s2 + bb_s2;
			m_s3    <= m_s2;

			mn_lo_s4 <= mn_lo_c;
			mn_hi_s4 <= mn_hi_c;
			m_s4     <= m_s3;

			mn_s5 <= {mn_hi_s4, {NORM_LO_WIDTH{1'b0}}} + MN_WIDTH'(mn_lo_s4);
			m_s5  <= m_s4;

			bnd_lo_s6 <= bnd_lo_c;
			bnd_hi_s6 <= bnd_hi_c;

			bound_s7 <= {bnd_hi_s6, {MN_LO_WIDTH{1'b0}}} + BOUND_WIDTH'(bnd_lo_s6);
		end
	end

	assign coef.a     = a_s1;
	assign coef.b     = b_s1;
	assign coef.c     = c_s2;
	assign coef.bound = bound_s7;

endmodule

`default_nettype wire

FILE: src/lspf_point_dist.sv
// Squared distance numerator (a*x+b*y+c)^2 of one endpoint, in six stages
// that advance together with the filter pipeline.
// Depends on lspf_pkg.
`default_nettype none

module lspf_point_dist import lspf_pkg::*; (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  line_coef_t                    coef,
	output logic [SQ_WIDTH-1:0]           sq
);

	logic signed [LINE_WIDTH-1:0] a, b;
	logic signed [C_WIDTH-1:0]    c;
	logic signed [TERM_WIDTH-1:0] ax_c, by_c;
	logic signed [TERM_WIDTH-1:0] ax_s2, by_s2;
	logic signed [SUM_WIDTH-1:0]  e_s3;
	logic [MAG_WIDTH-1:0]         mag_s4;
	logic [MAG_LO_WIDTH-1:0]      mag_lo;
	logic [MAG_HI_WIDTH-1:0]      mag_hi;
	logic [2*MAG_LO_WIDTH-1:0]    lo2_c, lo2_s5;
	logic [MAG_LO_WIDTH+MAG_HI_WIDTH-1:0] cross_c, cross_s5;
	logic [2*MAG_HI_WIDTH-1:0]    hi2_c, hi2_s5, hi2_s6;
	logic [PART_WIDTH-1:0]        part_s6;
	logic [SQ_WIDTH-1:0]          sq_s7;

	assign a = coef.a;
	assign b = coef.b;
	assign c = coef.c;

	assign ax_c = a * x;
	assign by_c = b * y;

	assign mag_lo = mag_s4[MAG_LO_WIDTH-1:0];
	assign mag_hi = mag_s4[MAG_WIDTH-1:MAG_LO_WIDTH];

	assign lo2_c   = mag_lo * mag_lo;
	assign cross_c = mag_lo * mag_hi;
	assign hi2_c   = mag_hi * mag_hi;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2 <= ax_c;
			by_s2 <= by_c;

			e_s3 <= SUM_WIDTH'(ax_s2) + SUM_WIDTH'(by_s2) + SUM_WIDTH'(c);

			mag_s4 <= e_s3[SUM_WIDTH-1] ? MAG_WIDTH'(-e_s3) : MAG_WIDTH'(e_s3);

			lo2_s5   <= lo2_c;
			cross_s5 <= cross_c;
			hi2_s5   <= hi2_c;

			// The cross term appears twice, hence the extra shift by one.
			part_s6 <= PART_WIDTH'(lo2_s5)
				+ PART_WIDTH'({cross_s5, {(MAG_LO_WIDTH + 1){1'b0}}});
			hi2_s6  <= hi2_s5;

			sq_s7 <= {hi2_s6, {(2 * MAG_LO_WIDTH){1'b0}}} + SQ_WIDTH'(part_s6);
		end
	end

	assign sq = sq_s7;

endmodule

`default_nettype wire

FILE: bench/lspf_verdict_checker.sv
`timescale 1ns / 100ps
// Checker of the line segment proximity filter: follows the register writes, predicts one
// verdict word per accepted segment and compares the result channel against it in order.
// Depends on lspf_pkg, lspf_seg_if and lspf_res_if.

module lspf_verdict_checker import lspf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	lspf_seg_if                        seg,
	lspf_res_if                        res,
	output int                         fail_count,
	output int                         pending_count
);

	localparam int PRINT_LIMIT = 40;

	// Wide enough for margin^2 * (a^2 + b^2) and for the squared line distance.
	typedef logic signed [127:0] acc_t;

	typedef struct packed {
		logic                   accepted;
		logic [INDEX_WIDTH-1:0] index;
		logic                   last;
	} verdict_t;

	logic signed [COORD_WIDTH-1:0]     line_x1, line_y1, line_x2, line_y2;
	logic [MARGIN_WIDTH-1:0]           margin;
	logic signed [LEVEL_REG_WIDTH-1:0] low_level, high_level;
	verdict_t                          verdict_q[$];

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("%0t ns verdict mismatch: %s", $time, msg);
	endtask

	function automatic logic beyond_margin(input acc_t a, input acc_t b, input acc_t c,
			input acc_t bound, input logic signed [COORD_WIDTH-1:0] px,
			input logic signed [COORD_WIDTH-1:0] py);
		acc_t line_dist;
		line_dist = a * px + b * py + c;
		if (line_dist < 0)
			line_dist = -line_dist;
		return line_dist * line_dist > bound;
	endfunction

	function automatic verdict_t judge_segment(input logic signed [COORD_WIDTH-1:0] sx,
			input logic signed [COORD_WIDTH-1:0] sy, input logic signed [COORD_WIDTH-1:0] ex,
			input logic signed [COORD_WIDTH-1:0] ey, input logic [LEVEL_WIDTH-1:0] level,
			input logic [INDEX_WIDTH-1:0] index, input logic last);
		acc_t     x1, y1, x2, y2, a, b, c, m, bound;
		int       lo, hi, lvl;
		verdict_t v;
		x1 = line_x1;
		y1 = line_y1;
		x2 = line_x2;
		y2 = line_y2;
		m = margin;
		a = y1 - y2;
		b = x2 - x1;
		c = x1 * y2 - y1 * x2;
		bound = m * m * (a * a + b * b);
		lo = low_level;
		hi = high_level;
		lvl = level;
		v.accepted = !(beyond_margin(a, b, c, bound, sx, sy) ||
			beyond_margin(a, b, c, bound, ex, ey));
		// The level range only counts once one of its two limits is switched on.
		if (lo > 0 || hi >= 0) begin
			if (lvl < lo)
				v.accepted = 1'b0;
			if (hi > 0 && lvl > hi)
				v.accepted = 1'b0;
		end
		v.index = index;
		v.last = last;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			line_x1 = '0;
			line_y1 = '0;
			line_x2 = '0;
			line_y2 = '0;
			margin = '0;
			low_level = '1;
			high_level = '1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_X:  line_x1 = cfg_data;
					REG_START_Y:  line_y1 = cfg_data;
					REG_END_X:    line_x2 = cfg_data;
					REG_END_Y:    line_y2 = cfg_data;
					REG_MARGIN:   margin = cfg_data[MARGIN_WIDTH-1:0];
					REG_LOW_LVL:  low_level = cfg_data[LEVEL_REG_WIDTH-1:0];
					REG_HIGH_LVL: high_level = cfg_data[LEVEL_REG_WIDTH-1:0];
					default: ;
				endcase
			end
			if (seg.valid && seg.ready)
				verdict_q.insert(verdict_q.size(), judge_segment(seg.seg_start_x,
					seg.seg_start_y, seg.seg_end_x, seg.seg_end_y, seg.seg_level,
					seg.seg_index, seg.seg_last));
			if (res.valid && res.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("verdict word with nothing pending, index %0d",
						res.out_index));
				end else begin
					want = verdict_q.pop_front();
					if (res.accepted !== want.accepted)
						report_mismatch($sformatf("index %0d: accepted %b, predicted %b",
							want.index, res.accepted, want.accepted));
					if (res.out_index !== want.index)
						report_mismatch($sformatf("out_index %0d, predicted %0d",
							res.out_index, want.index));
					if (res.out_last !== want.last)
						report_mismatch($sformatf("index %0d: out_last %b, predicted %b",
							want.index, res.out_last, want.last));
				end
			end
			pending_count = verdict_q.size();
		end
	end

endmodule

FILE: bench/tb_line_segment_proximity_filter.sv
`timescale 1ns / 100ps
// Top of the proximity filter testbench: clock, reset, register settings, segment stimulus
// and result back-pressure; the verdict comes from the failure count of the checker.
// Depends on lspf_pkg, the channel interfaces, the filter and lspf_verdict_checker.

module tb_line_segment_proximity_filter;
	import lspf_pkg::*;

	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;
	localparam int HOLD_OFF_CYCLES = 70;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_WORDS     = 100;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
		logic [LEVEL_WIDTH-1:0]        level;
		logic [INDEX_WIDTH-1:0]        index;
		logic                          last;
	} segment_t;

	localparam int SEG_BITS = $bits(segment_t);

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;
	int                         fail_count;
	int                         pending_count;
	bit                         sender_burst;
	bit                         receiver_burst;
	int                         cur_x1, cur_y1, cur_x2, cur_y2, cur_margin;

	lspf_seg_if seg ();
	lspf_res_if res ();

	line_segment_proximity_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.seg       (seg),
		.res       (res)
	);

	lspf_verdict_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.seg           (seg),
		.res           (res),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_line_segment_proximity_filter failed");
		$finish;
	end

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic segment_t make_segment(input int sx, input int sy, input int ex,
			input int ey, input int level);
		segment_t s;
		s.start_x = sx[COORD_WIDTH-1:0];
		s.start_y = sy[COORD_WIDTH-1:0];
		s.end_x = ex[COORD_WIDTH-1:0];
		s.end_y = ey[COORD_WIDTH-1:0];
		s.level = level[LEVEL_WIDTH-1:0];
		s.index = INDEX_WIDTH'($urandom);
		s.last = 1'($urandom_range(0, 1));
		return s;
	endfunction

	// A point at fraction t/256 along the reference line, pushed off it by up to off.
	function automatic int near_line_coord(input int base, input int delta, input int t,
			input int off);
		return base + (delta * t) / 256 + rand_between(-off, off);
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_WIDTH-1:0];
		@(posedge clk);
	endtask

	task automatic apply_setting(input int x1, input int y1, input int x2, input int y2,
			input int margin, input int lo, input int hi);
		write_reg(REG_START_X, x1);
		write_reg(REG_START_Y, y1);
		write_reg(REG_END_X, x2);
		write_reg(REG_END_Y, y2);
		write_reg(REG_MARGIN, margin);
		write_reg(REG_LOW_LVL, lo);
		write_reg(REG_HIGH_LVL, hi);
		write_reg(REG_SPARE, $urandom);
		cfg_we <= 1'b0;
		cur_x1 = x1;
		cur_y1 = y1;
		cur_x2 = x2;
		cur_y2 = y2;
		cur_margin = margin;
		// Give the coefficient pipeline time to pick up the new line.
		repeat (12) @(posedge clk);
	endtask

	task automatic send_segment(input segment_t s);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			seg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg.valid <= 1'b1;
		seg.seg_start_x <= s.start_x;
		seg.seg_start_y <= s.start_y;
		seg.seg_end_x <= s.end_x;
		seg.seg_end_y <= s.end_y;
		seg.seg_level <= s.level;
		seg.seg_index <= s.index;
		seg.seg_last <= s.last;
		do @(posedge clk); while (!seg.ready);
	endtask

	// Stop offering words, wait for every verdict and let the pipeline run empty.
	task automatic settle();
		seg.valid <= 1'b0;
		do @(negedge clk); while (pending_count != 0);
		repeat (12) @(posedge clk);
	endtask

	// Result side: random stalls, stretches without any, and two long hold-offs
	// while the sender keeps offering words.
	initial begin
		int stall;
		int taken;
		taken = 0;
		res.ready <= 1'b0;
		receiver_burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = receiver_burst ? 0 : $urandom_range(0, 11);
			if (taken == 160 || taken == 430)
				stall = HOLD_OFF_CYCLES;
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			taken++;
			if (taken % 50 == 0)
				receiver_burst = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin
		segment_t s;
		int       x1, y1, x2, y2, margin, lo, hi;
		int       t0, t1, off;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_START_X;
		cfg_data <= '0;
		seg.valid <= 1'b0;
		seg.seg_start_x <= '0;
		seg.seg_start_y <= '0;
		seg.seg_end_x <= '0;
		seg.seg_end_y <= '0;
		seg.seg_level <= '0;
		seg.seg_index <= '0;
		seg.seg_last <= 1'b0;
		sender_burst = 1'b0;
		cur_x1 = 0;
		cur_y1 = 0;
		cur_x2 = 0;
		cur_y2 = 0;
		cur_margin = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset values: a line collapsed to the origin and no level range.
		s = make_segment(524287, 524287, 524287, 524287, 31);
		s.index = '1;
		s.last = 1'b1;
		send_segment(s);
		s = make_segment(-524288, -524288, -524288, -524288, 0);
		s.index = '0;
		s.last = 1'b0;
		send_segment(s);
		send_segment(make_segment(-524288, 524287, 524287, -524288, 17));

		// Horizontal line with a margin of 80 units and levels two to five.
		settle();
		apply_setting(-1600, 0, 1600, 0, 80, 2, 5);
		send_segment(make_segment(0, 0, 1600, 0, 3));
		send_segment(make_segment(-400, 80, 400, 0, 3));
		send_segment(make_segment(-400, -80, 400, 80, 4));
		send_segment(make_segment(-400, 81, 400, 0, 3));
		send_segment(make_segment(-400, 0, 400, -81, 3));
		send_segment(make_segment(-400, 0, 400, 0, 1));
		send_segment(make_segment(-400, 0, 400, 0, 2));
		send_segment(make_segment(-400, 0, 400, 0, 5));
		send_segment(make_segment(-400, 0, 400, 0, 6));
		send_segment(make_segment(524287, 524287, -524288, -524288, 3));

		// Diagonal through the extreme corners, largest margin, level limits both zero.
		settle();
		apply_setting(-524288, -524288, 524287, 524287, 524287, 0, 0);
		send_segment(make_segment(524287, -524288, 0, 0, 9));
		send_segment(make_segment(1000, 1000, -524288, -524288, 31));
		send_segment(make_segment(0, 524287, 524287, 0, 0));

		// Vertical line with no margin at all, only level 31 allowed.
		settle();
		apply_setting(16, -100, 16, 100, 0, 31, -1);
		send_segment(make_segment(16, -524288, 16, 524287, 31));
		send_segment(make_segment(16, 0, 16, 50, 30));
		send_segment(make_segment(17, 0, 16, 50, 31));

		// Both reference points equal away from the origin; upper level limit at the top.
		settle();
		apply_setting(5000, -7000, 5000, -7000, 0, -1, 31);
		send_segment(make_segment(-524288, 524287, 123456, -98765, 0));
		send_segment(make_segment(524287, -524288, -1, 1, 31));

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			case ($urandom_range(0, 5))
				0: begin
					x1 = rand_between(-524288, 524287);
					y1 = rand_between(-524288, 524287);
					x2 = rand_between(-524288, 524287);
					y2 = rand_between(-524288, 524287);
				end
				1: begin
					x1 = rand_between(-65536, 65535);
					y1 = rand_between(-65536, 65535);
					x2 = x1;
					y2 = y1;
				end
				default: begin
					x1 = rand_between(-65536, 65535);
					y1 = rand_between(-65536, 65535);
					x2 = rand_between(-65536, 65535);
					y2 = rand_between(-65536, 65535);
				end
			endcase
			case ($urandom_range(0, 5))
				0:       margin = 0;
				1:       margin = 524287;
				2:       margin = rand_between(0, 524287);
				default: margin = rand_between(0, 2048);
			endcase
			case ($urandom_range(0, 3))
				0:       lo = -1;
				1:       lo = rand_between(-32, 31);
				default: lo = rand_between(0, 8);
			endcase
			case ($urandom_range(0, 3))
				0:       hi = -1;
				1:       hi = rand_between(-32, 31);
				default: hi = rand_between(8, 31);
			endcase
			apply_setting(x1, y1, x2, y2, margin, lo, hi);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 40 == 0)
					sender_burst = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 3) == 0) begin
					s = SEG_BITS'({$urandom, $urandom, $urandom, $urandom});
				end else begin
					// Endpoints scattered around the line, some inside the margin and some out.
					off = cur_margin * 2 + 2;
					t0 = rand_between(-256, 512);
					t1 = rand_between(-256, 512);
					s = make_segment(near_line_coord(cur_x1, cur_x2 - cur_x1, t0, off),
						near_line_coord(cur_y1, cur_y2 - cur_y1, t0, off),
						near_line_coord(cur_x1, cur_x2 - cur_x1, t1, off),
						near_line_coord(cur_y1, cur_y2 - cur_y1, t1, off),
						$urandom_range(0, 31));
					s.last = ($urandom_range(0, 7) == 0);
				end
				send_segment(s);
			end
		end

		settle();
		if (fail_count == 0) begin
			$display("tb_line_segment_proximity_filter passed");
		end else begin
			$display("tb_line_segment_proximity_filter failed");
		end
		$finish;
	end

endmodule
